[design/kes_pkg.sv]
`default_nettype none
package kes_pkg;

    localparam int ANGLE_FRAC_BITS = 28;
    localparam int ANG_W           = 31;
    localparam int X_SHIFT         = 60 - ANGLE_FRAC_BITS;
    localparam int ESIN_SHIFT      = 91 - ANGLE_FRAC_BITS;
    localparam int ECOS_SHIFT      = 31;
    localparam int TERM_SHIFT      = 60;
    localparam int TERM_LAST       = 21;
    localparam int NDIV_BITS       = 93;

    localparam logic [63:0] TWO_PI_Q60  = 64'h6487ED5110B4611A;
    localparam logic [63:0] HALF_PI_Q60 = TWO_PI_Q60 >> 2;
    localparam logic [63:0] ONE_Q60     = 64'h1000000000000000;
    localparam logic [ANG_W-1:0] TWO_PI_ANG = ANG_W'(TWO_PI_Q60 >> (60 - ANGLE_FRAC_BITS));
    localparam logic [ANG_W-1:0] PI_ANG     = ANG_W'(TWO_PI_Q60 >> (61 - ANGLE_FRAC_BITS));

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK      = 2'd0;
    localparam status_t STATUS_ECC_ERR = 2'd1;
    localparam status_t STATUS_NO_CONV = 2'd2;

    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_TOLERANCE       = 2'd0;
    localparam reg_idx_t REG_ITERATION_LIMIT = 2'd1;
    localparam reg_idx_t REG_START_THRESHOLD = 2'd2;

    localparam logic [19:0] TOLERANCE_RST = 20'd4;
    localparam logic [5:0]  LIMIT_RST     = 6'd50;
    localparam logic [30:0] THRESHOLD_RST = 31'd1717986918;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_REDUCE = 10'b0000000010,
        S_QUAD   = 10'b0000000100,
        S_TMUL   = 10'b0000001000,
        S_TDIV   = 10'b0000010000,
        S_MAP    = 10'b0000100000,
        S_ESIN   = 10'b0001000000,
        S_ECOS   = 10'b0010000000,
        S_NDIV   = 10'b0100000000,
        S_UPDATE = 10'b1000000000
    } state_t;

endpackage
`default_nettype wire

[design/kepler_equation_solver.sv]
// Channel   Ports                                        Handshake
// input     start, busy, mean_anomaly, eccentricity      start & !busy
// result    done, ecc_anomaly, status, steps_used        done, one cycle
// config    cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid & cfg_ready
//
// One item per Newton solve; busy drops in the cycle that carries the result strobe.
// A Newton step runs the quadrant reduction, 21 series terms (each a product on the
// shared 32x32 multiplier and a division on the radix-256 small divider), the quadrant
// map, two products, a 93-bit quotient at one bit per cycle and the update.
// An item takes the reduction of its mean anomaly plus up to iteration_limit steps (one if zero);
// an item with bad eccentricity returns its result in the next cycle.
// Asynchronous active-low reset; results cannot be stalled.
`default_nettype none
module kepler_equation_solver
    import kes_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] mean_anomaly,
    input  wire logic        [31:0] eccentricity,
    output logic                    done,
    output logic signed [31:0]      ecc_anomaly,
    output logic [1:0]              status,
    output logic [5:0]              steps_used,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    logic [19:0] tolerance_reg;
    logic [5:0]  limit_reg;
    logic [30:0] threshold_reg;

    state_t state_reg, state_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic signed [32:0] m_reg, m_next;
    logic [30:0]  ecc_reg, ecc_next;
    logic [ANG_W-1:0] e_reg, e_next;
    logic [63:0]  r_reg, r_next;
    logic [1:0]   quad_reg, quad_next;
    logic [4:0]   k_reg, k_next;
    logic signed [63:0] s_reg, s_next, c_reg, c_next;
    logic [63:0]  mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic [127:0] acc_reg, acc_next;
    logic [63:0]  dq_reg, dq_next;
    logic [4:0]   krem_reg, krem_next;
    logic         sn_neg_reg, sn_neg_next;
    logic [63:0]  cs_mag_reg, cs_mag_next;
    logic signed [33:0] f_reg, f_next;
    logic [32:0]  fmag_reg, fmag_next;
    logic [63:0]  den_reg, den_next;
    logic [NDIV_BITS-1:0] nd_reg, nd_next;
    logic [63:0]  rem_reg, rem_next, quot_reg, quot_next;
    logic         sat_reg, sat_next;
    logic [5:0]   steps_reg, steps_next;
    logic         done_reg, done_next;
    logic [31:0]  ecc_anomaly_reg, ecc_anomaly_next;
    status_t      status_reg, status_next;
    logic [5:0]   steps_used_reg, steps_used_next;

    logic [31:0]  a_sel, b_sel;
    logic [63:0]  pp;
    logic [127:0] pp_sh;

    assign a_sel = cnt_reg[0] ? mul_a_reg[63:32] : mul_a_reg[31:0];
    assign b_sel = cnt_reg[1] ? mul_b_reg[63:32] : mul_b_reg[31:0];
    assign pp    = 64'(a_sel) * 64'(b_sel);
    assign pp_sh = 128'(pp) << {cnt_reg[0] & cnt_reg[1], cnt_reg[0] ^ cnt_reg[1], 5'b0};

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign done        = done_reg;
    assign ecc_anomaly = ecc_anomaly_reg;
    assign status      = status_reg;
    assign steps_used  = steps_used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOLERANCE_RST;
            limit_reg     <= LIMIT_RST;
            threshold_reg <= THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TOLERANCE)
                tolerance_reg <= cfg_data[19:0];
            else if (cfg_index == REG_ITERATION_LIMIT)
                limit_reg <= cfg_data[5:0];
            else if (cfg_index == REG_START_THRESHOLD)
                threshold_reg <= cfg_data[30:0];
        end
    end

    always_comb
    begin
        logic [63:0]  t_dq;
        logic [4:0]   t_rem;
        logic [5:0]   r6;
        logic         ge;
        logic [63:0]  term_new;
        logic [63:0]  prod;
        logic signed [63:0] sn, cs;
        logic [33:0]  esin_mag;
        logic signed [33:0] esin, fv;
        logic [63:0]  ecos, den;
        logic [63:0]  rem_s;
        logic [63:0]  qmag;
        logic [ANG_W-1:0] q, e_new;
        logic [5:0]   limit, st_new;

        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_next       = m_reg;
        ecc_next     = ecc_reg;
        e_next       = e_reg;
        r_next       = r_reg;
        quad_next    = quad_reg;
        k_next       = k_reg;
        s_next       = s_reg;
        c_next       = c_reg;
        mul_a_next   = mul_a_reg;
        mul_b_next   = mul_b_reg;
        acc_next     = acc_reg;
        dq_next      = dq_reg;
        krem_next    = krem_reg;
        sn_neg_next  = sn_neg_reg;
        cs_mag_next  = cs_mag_reg;
        f_next       = f_reg;
        fmag_next    = fmag_reg;
        den_next     = den_reg;
        nd_next      = nd_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        sat_next     = sat_reg;
        steps_next   = steps_reg;
        done_next    = 1'b0;
        ecc_anomaly_next = ecc_anomaly_reg;
        status_next      = status_reg;
        steps_used_next  = steps_used_reg;

        t_dq = dq_reg;
        t_rem = krem_reg;
        r6 = '0;
        ge = 1'b0;
        term_new = '0;
        prod = '0;
        sn = '0;
        cs = '0;
        esin_mag = '0;
        esin = '0;
        fv = '0;
        ecos = '0;
        den = '0;
        rem_s = '0;
        qmag = '0;
        q = '0;
        e_new = e_reg;
        limit = (limit_reg == 6'd0) ? 6'd1 : limit_reg;
        st_new = steps_reg + 6'd1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (eccentricity[31])
                    begin
                        done_next        = 1'b1;
                        ecc_anomaly_next = '0;
                        status_next      = STATUS_ECC_ERR;
                        steps_used_next  = '0;
                    end
                    else
                    begin
                        m_next     = 33'(mean_anomaly);
                        ecc_next   = eccentricity[30:0];
                        steps_next = '0;
                        state_next = S_REDUCE;
                    end
                end
            end
            S_REDUCE:
            begin
                if (m_reg >= $signed({2'b0, TWO_PI_ANG}))
                    m_next = m_reg - $signed({2'b0, TWO_PI_ANG});
                else if (m_reg < 0)
                    m_next = m_reg + $signed({2'b0, TWO_PI_ANG});
                else
                begin
                    e_next     = (ecc_reg < threshold_reg) ? m_reg[ANG_W-1:0] : PI_ANG;
                    r_next     = 64'(e_next) << X_SHIFT;
                    quad_next  = '0;
                    cnt_next   = '0;
                    state_next = S_QUAD;
                end
            end
            S_QUAD:
            begin
                if (r_reg >= HALF_PI_Q60)
                begin
                    r_next    = r_reg - HALF_PI_Q60;
                    quad_next = quad_reg + 2'd1;
                end
                if (cnt_reg == 7'd3)
                begin
                    s_next     = '0;
                    c_next     = $signed(ONE_Q60);
                    k_next     = 5'd1;
                    mul_a_next = ONE_Q60;
                    mul_b_next = r_next;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = S_TMUL;
                end
                else
                    cnt_next = cnt_reg + 7'd1;
            end
            S_TMUL:
            begin
                if (cnt_reg != 7'd4)
                begin
                    acc_next = acc_reg + pp_sh;
                    cnt_next = cnt_reg + 7'd1;
                end
                else
                begin
                    dq_next    = 64'(acc_reg >> TERM_SHIFT);
                    krem_next  = '0;
                    cnt_next   = '0;
                    state_next = S_TDIV;
                end
            end
            S_TDIV:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    r6 = {t_rem, t_dq[63]};
                    ge = (r6 >= {1'b0, k_reg});
                    t_rem = ge ? 5'(r6 - {1'b0, k_reg}) : r6[4:0];
                    t_dq = {t_dq[62:0], ge};
                end
                dq_next   = t_dq;
                krem_next = t_rem;
                if (cnt_reg == 7'd7)
                begin
                    term_new = t_dq;
                    unique case (k_reg[1:0])
                        2'd1: s_next = s_reg + $signed(term_new);
                        2'd2: c_next = c_reg - $signed(term_new);
                        2'd3: s_next = s_reg - $signed(term_new);
                        default: c_next = c_reg + $signed(term_new);
                    endcase
                    cnt_next = '0;
                    if (k_reg == 5'(TERM_LAST))
                        state_next = S_MAP;
                    else
                    begin
                        k_next     = k_reg + 5'd1;
                        mul_a_next = term_new;
                        mul_b_next = r_reg;
                        acc_next   = '0;
                        state_next = S_TMUL;
                    end
                end
                else
                    cnt_next = cnt_reg + 7'd1;
            end
            S_MAP:
            begin
                unique case (quad_reg)
                    2'd0: begin sn = s_reg;  cs = c_reg;  end
                    2'd1: begin sn = c_reg;  cs = -s_reg; end
                    2'd2: begin sn = -s_reg; cs = -c_reg; end
                    default: begin sn = -c_reg; cs = s_reg; end
                endcase
                sn_neg_next = sn[63];
                cs_mag_next = cs[63] ? 64'(-cs) : 64'(cs);
                mul_a_next  = 64'(ecc_reg);
                mul_b_next  = sn[63] ? 64'(-sn) : 64'(sn);
                f_next      = {33'b0, cs[63]};
                acc_next    = '0;
                cnt_next    = '0;
                state_next  = S_ESIN;
            end
            S_ESIN:
            begin
                if (cnt_reg != 7'd4)
                begin
                    acc_next = acc_reg + pp_sh;
                    cnt_next = cnt_reg + 7'd1;
                end
                else
                begin
                    prod     = 64'(acc_reg >> ESIN_SHIFT);
                    esin_mag = prod[33:0];
                    esin     = sn_neg_reg ? -$signed(esin_mag) : $signed(esin_mag);
                    fv       = $signed(34'(e_reg)) - $signed(34'(m_reg[ANG_W-1:0])) - esin;
                    // keep cosine sign for the denominator in den_reg bit 0 meanwhile
                    den_next   = {63'b0, f_reg[0]};
                    f_next     = fv;
                    fmag_next  = fv[33] ? 33'(-fv) : 33'(fv);
                    mul_b_next = cs_mag_reg;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = S_ECOS;
                end
            end
            S_ECOS:
            begin
                if (cnt_reg != 7'd4)
                begin
                    acc_next = acc_reg + pp_sh;
                    cnt_next = cnt_reg + 7'd1;
                end
                else
                begin
                    ecos = 64'(acc_reg >> ECOS_SHIFT);
                    if (den_reg[0])
                        den = ONE_Q60 + ecos;
                    else
                        den = (ecos >= ONE_Q60) ? 64'd0 : ONE_Q60 - ecos;
                    if (den == 64'd0)
                        den = 64'd1;
                    den_next   = den;
                    nd_next    = {fmag_reg, 60'b0};
                    rem_next   = '0;
                    quot_next  = '0;
                    sat_next   = 1'b0;
                    cnt_next   = '0;
                    state_next = S_NDIV;
                end
            end
            S_NDIV:
            begin
                rem_s     = {rem_reg[62:0], nd_reg[NDIV_BITS-1]};
                ge        = (rem_s >= den_reg);
                nd_next   = nd_reg << 1;
                sat_next  = sat_reg | quot_reg[63];
                quot_next = {quot_reg[62:0], ge};
                rem_next  = ge ? rem_s - den_reg : rem_s;
                if (cnt_reg == 7'(NDIV_BITS - 1))
                    state_next = S_UPDATE;
                else
                    cnt_next = cnt_reg + 7'd1;
            end
            S_UPDATE:
            begin
                qmag = sat_reg ? '1 : quot_reg;
                q = (qmag > 64'(TWO_PI_ANG)) ? TWO_PI_ANG : qmag[ANG_W-1:0];
                if (f_reg > 0)
                    e_new = (q > e_reg) ? '0 : e_reg - q;
                else if (f_reg < 0)
                    e_new = (q > TWO_PI_ANG - e_reg) ? TWO_PI_ANG : e_reg + q;
                e_next     = e_new;
                steps_next = st_new;
                if (st_new == limit)
                begin
                    done_next        = 1'b1;
                    ecc_anomaly_next = '0;
                    status_next      = STATUS_NO_CONV;
                    steps_used_next  = st_new;
                    state_next       = S_IDLE;
                end
                else if (fmag_reg > 33'(tolerance_reg))
                begin
                    r_next     = 64'(e_new) << X_SHIFT;
                    quad_next  = '0;
                    cnt_next   = '0;
                    state_next = S_QUAD;
                end
                else
                begin
                    done_next        = 1'b1;
                    ecc_anomaly_next = 32'(e_new);
                    status_next      = STATUS_OK;
                    steps_used_next  = st_new;
                    state_next       = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            steps_reg <= '0;
            status_reg <= STATUS_OK;
            steps_used_reg <= '0;
            ecc_anomaly_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            steps_reg <= steps_next;
            status_reg <= status_next;
            steps_used_reg <= steps_used_next;
            ecc_anomaly_reg <= ecc_anomaly_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg      <= m_next;
        ecc_reg    <= ecc_next;
        e_reg      <= e_next;
        r_reg      <= r_next;
        quad_reg   <= quad_next;
        k_reg      <= k_next;
        s_reg      <= s_next;
        c_reg      <= c_next;
        mul_a_reg  <= mul_a_next;
        mul_b_reg  <= mul_b_next;
        acc_reg    <= acc_next;
        dq_reg     <= dq_next;
        krem_reg   <= krem_next;
        sn_neg_reg <= sn_neg_next;
        cs_mag_reg <= cs_mag_next;
        f_reg      <= f_next;
        fmag_reg   <= fmag_next;
        den_reg    <= den_next;
        nd_reg     <= nd_next;
        rem_reg    <= rem_next;
        quot_reg   <= quot_next;
        sat_reg    <= sat_next;
    end

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result strobe while busy");
    a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done) else $error("accepted item dropped");
    a_ecc_err: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STATUS_ECC_ERR |-> ecc_anomaly == 0 && steps_used == 0)
        else $error("bad eccentricity result");
    a_ok_steps: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STATUS_OK |-> steps_used != 0 && !ecc_anomaly[31])
        else $error("ok result without steps");
    a_noconv: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == STATUS_NO_CONV |-> ecc_anomaly == 0 && steps_used != 0)
        else $error("no-convergence result malformed");
`endif

endmodule
`default_nettype wire
